### rtl/mkd_pkg.sv
// shared types, constants and the morse pattern rom for the key timing decoder
`default_nettype none

package mkd_pkg;

    localparam int CFG_BITS      = 16;
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;
    localparam int CHAR_BITS     = 7;
    localparam int PAT_MAX       = 8;
    localparam int PAT_LEN_BITS  = 4;

    localparam logic [1:0] REG_DASH_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_CHAR_GAP       = 2'd1;
    localparam logic [1:0] REG_WORD_GAP       = 2'd2;
    localparam logic [1:0] REG_DEBOUNCE_TICKS = 2'd3;

    localparam logic [CFG_BITS-1:0] DASH_THRESHOLD_RESET = 16'd180;
    localparam logic [CFG_BITS-1:0] CHAR_GAP_RESET       = 16'd180;
    localparam logic [CFG_BITS-1:0] WORD_GAP_RESET       = 16'd420;
    localparam logic [CFG_BITS-1:0] DEBOUNCE_TICKS_RESET = 16'd5;

    localparam logic [CHAR_BITS-1:0] CHAR_SPACE   = 7'h20;
    localparam logic [CHAR_BITS-1:0] CHAR_UNKNOWN = 7'h23;
    localparam logic [CHAR_BITS-1:0] CHAR_NONE    = 7'h00;

    typedef struct packed {
        logic [CFG_BITS-1:0] dash_threshold;
        logic [CFG_BITS-1:0] char_gap;
        logic [CFG_BITS-1:0] word_gap;
        logic [CFG_BITS-1:0] debounce_ticks;
    } cfg_t;

    typedef struct packed {
        logic                 tone_on;
        logic                 char_valid;
        logic [CHAR_BITS-1:0] char_code;
    } res_t;

    // symbol i of the pattern sits in bit i, dash is 1
    function automatic logic [CHAR_BITS-1:0] morse_lookup(
        input logic [PAT_LEN_BITS-1:0] len,
        input logic [PAT_MAX-1:0]      bits
    );
        logic [CHAR_BITS-1:0] code;
        case ({len, bits})
            {4'd2, 8'b10}:     code = 7'h41;
            {4'd4, 8'b0001}:   code = 7'h42;
            {4'd4, 8'b0101}:   code = 7'h43;
            {4'd3, 8'b001}:    code = 7'h44;
            {4'd1, 8'b0}:      code = 7'h45;
            {4'd4, 8'b0100}:   code = 7'h46;
            {4'd3, 8'b011}:    code = 7'h47;
            {4'd4, 8'b0000}:   code = 7'h48;
            {4'd2, 8'b00}:     code = 7'h49;
            {4'd4, 8'b1110}:   code = 7'h4A;
            {4'd3, 8'b101}:    code = 7'h4B;
            {4'd4, 8'b0010}:   code = 7'h4C;
            {4'd2, 8'b11}:     code = 7'h4D;
            {4'd2, 8'b01}:     code = 7'h4E;
            {4'd3, 8'b111}:    code = 7'h4F;
            {4'd4, 8'b0110}:   code = 7'h50;
            {4'd4, 8'b1011}:   code = 7'h51;
            {4'd3, 8'b010}:    code = 7'h52;
            {4'd3, 8'b000}:    code = 7'h53;
            {4'd1, 8'b1}:      code = 7'h54;
            {4'd3, 8'b100}:    code = 7'h55;
            {4'd4, 8'b1000}:   code = 7'h56;
            {4'd3, 8'b110}:    code = 7'h57;
            {4'd4, 8'b1001}:   code = 7'h58;
            {4'd4, 8'b1101}:   code = 7'h59;
            {4'd4, 8'b0011}:   code = 7'h5A;
            {4'd5, 8'b11111}:  code = 7'h30;
            {4'd5, 8'b11110}:  code = 7'h31;
            {4'd5, 8'b11100}:  code = 7'h32;
            {4'd5, 8'b11000}:  code = 7'h33;
            {4'd5, 8'b10000}:  code = 7'h34;
            {4'd5, 8'b00000}:  code = 7'h35;
            {4'd5, 8'b00001}:  code = 7'h36;
            {4'd5, 8'b00011}:  code = 7'h37;
            {4'd5, 8'b00111}:  code = 7'h38;
            {4'd5, 8'b01111}:  code = 7'h39;
            {4'd6, 8'b101010}: code = 7'h2E;
            {4'd6, 8'b110011}: code = 7'h2C;
            {4'd6, 8'b000111}: code = 7'h3A;
            {4'd6, 8'b001100}: code = 7'h3F;
            {4'd6, 8'b011110}: code = 7'h27;
            {4'd6, 8'b100001}: code = 7'h2D;
            {4'd5, 8'b01001}:  code = 7'h2F;
            {4'd5, 8'b01101}:  code = 7'h28;
            {4'd6, 8'b101101}: code = 7'h29;
            {4'd6, 8'b010010}: code = 7'h22;
            {4'd5, 8'b10001}:  code = 7'h3D;
            {4'd5, 8'b01010}:  code = 7'h2B;
            {4'd6, 8'b010110}: code = 7'h40;
            default:           code = CHAR_UNKNOWN;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### rtl/mkd_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module mkd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic                 re,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] rd_data_reg;

    generate
        if (DEPTH > 1) begin : g_array
            logic [WIDTH-1:0] mem_reg [DEPTH];

            always_ff @(posedge clk)
            begin
                if (we)
                begin
                    mem_reg[wr_addr] <= wr_data;
                end
                if (re)
                begin
                    rd_data_reg <= mem_reg[rd_addr];
                end
            end
        end else begin : g_single
            logic [WIDTH-1:0] mem_reg;

            always_ff @(posedge clk)
            begin
                if (we && (wr_addr == '0))
                begin
                    mem_reg <= wr_data;
                end
                if (re && (rd_addr == '0))
                begin
                    rd_data_reg <= mem_reg;
                end
            end
        end
    endgenerate

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/mkd_cfg.sv
// apb register block for the decoder timing settings
`default_nettype none

module mkd_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [mkd_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  wire logic [mkd_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic      [mkd_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                    pready,
    output mkd_pkg::cfg_t                           cfg
);

    import mkd_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] reg_index;
    logic       wr_en;
    logic [CFG_BITS-1:0] rd_value;

    assign pready    = 1'b1;
    assign reg_index = paddr[CFG_ADDR_BITS-1:2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index)
                REG_DASH_THRESHOLD: cfg_next.dash_threshold = pwdata[CFG_BITS-1:0];
                REG_CHAR_GAP:       cfg_next.char_gap       = pwdata[CFG_BITS-1:0];
                REG_WORD_GAP:       cfg_next.word_gap       = pwdata[CFG_BITS-1:0];
                REG_DEBOUNCE_TICKS: cfg_next.debounce_ticks = pwdata[CFG_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dash_threshold <= DASH_THRESHOLD_RESET;
            cfg_reg.char_gap       <= CHAR_GAP_RESET;
            cfg_reg.word_gap       <= WORD_GAP_RESET;
            cfg_reg.debounce_ticks <= DEBOUNCE_TICKS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_DASH_THRESHOLD: rd_value = cfg_reg.dash_threshold;
            REG_CHAR_GAP:       rd_value = cfg_reg.char_gap;
            REG_WORD_GAP:       rd_value = cfg_reg.word_gap;
            REG_DEBOUNCE_TICKS: rd_value = cfg_reg.debounce_ticks;
            default:            rd_value = '0;
        endcase
    end

    assign prdata = {{(CFG_DATA_BITS - CFG_BITS){1'b0}}, rd_value};
    assign cfg    = cfg_reg;

endmodule

`default_nettype wire

### rtl/mkd_step.sv
// per-tick state update: debounce gate, press timing, gap detection, rom lookup
`default_nettype none

module mkd_step #(
    parameter int TIME_BITS  = 16,
    parameter int SYMBOL_MAX = 6,
    localparam int LEN_BITS   = $clog2(SYMBOL_MAX + 1),
    localparam int STATE_BITS = 5 * TIME_BITS + 5 + SYMBOL_MAX + LEN_BITS
) (
    input  wire logic [STATE_BITS-1:0] cur_state,
    input  wire logic                  key_level,
    input  wire mkd_pkg::cfg_t         cfg,
    output logic      [STATE_BITS-1:0] next_state,
    output mkd_pkg::res_t              result
);

    import mkd_pkg::*;

    localparam int IDX_BITS = $clog2(SYMBOL_MAX);
    localparam int CMP_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;

    typedef struct packed {
        logic [TIME_BITS-1:0]  tick_now;
        logic [TIME_BITS-1:0]  gate_mark;
        logic [TIME_BITS-1:0]  press_start;
        logic [TIME_BITS-1:0]  symbol_time;
        logic [TIME_BITS-1:0]  char_time;
        logic                  press_active;
        logic                  symbol_time_valid;
        logic                  char_time_valid;
        logic                  garbage_flag;
        logic                  tone_state;
        logic [SYMBOL_MAX-1:0] pattern_bits;
        logic [LEN_BITS-1:0]   pattern_len;
    } state_t;

    state_t               cur;
    state_t               nxt;
    logic [TIME_BITS-1:0] gate_el;
    logic [TIME_BITS-1:0] press_el;
    logic [TIME_BITS-1:0] symbol_el;
    logic [TIME_BITS-1:0] char_el;
    logic                 gate_open;
    logic                 is_dash;
    logic                 word_done;
    logic                 char_done;
    logic                 pattern_full;
    logic [CHAR_BITS-1:0] lookup_code;

    assign cur = cur_state;

    assign gate_el   = cur.tick_now - cur.gate_mark;
    assign press_el  = cur.tick_now - cur.press_start;
    assign symbol_el = cur.tick_now - cur.symbol_time;
    assign char_el   = cur.tick_now - cur.char_time;

    assign gate_open = CMP_BITS'(gate_el) >= CMP_BITS'(cfg.debounce_ticks);
    assign is_dash   = CMP_BITS'(press_el) >= CMP_BITS'(cfg.dash_threshold);
    assign word_done = cur.char_time_valid
                       && (CMP_BITS'(char_el) >= CMP_BITS'(cfg.word_gap));
    assign char_done = cur.symbol_time_valid
                       && (CMP_BITS'(symbol_el) >= CMP_BITS'(cfg.char_gap));

    assign pattern_full = (cur.pattern_len >= LEN_BITS'(SYMBOL_MAX)) || cur.garbage_flag;
    assign lookup_code  = morse_lookup(PAT_LEN_BITS'(cur.pattern_len),
                                       PAT_MAX'(cur.pattern_bits));

    always_comb
    begin
        nxt               = cur;
        nxt.tick_now      = cur.tick_now + TIME_BITS'(1);
        result.char_valid = 1'b0;
        result.char_code  = CHAR_NONE;
        if (gate_open)
        begin
            if (key_level)
            begin
                if (!cur.press_active)
                begin
                    nxt.press_active = 1'b1;
                    nxt.press_start  = cur.tick_now;
                end
                nxt.tone_state = 1'b1;
            end
            else
            begin
                nxt.tone_state = 1'b0;
                if (cur.press_active)
                begin
                    if (pattern_full)
                    begin
                        nxt.garbage_flag = 1'b1;
                    end
                    else
                    begin
                        nxt.pattern_bits[cur.pattern_len[IDX_BITS-1:0]] = is_dash;
                        nxt.pattern_len       = cur.pattern_len + LEN_BITS'(1);
                        nxt.symbol_time       = cur.tick_now;
                        nxt.symbol_time_valid = 1'b1;
                        nxt.char_time_valid   = 1'b0;
                    end
                    nxt.press_active = 1'b0;
                    nxt.press_start  = '0;
                end
                else if (word_done)
                begin
                    result.char_valid   = 1'b1;
                    result.char_code    = CHAR_SPACE;
                    nxt.char_time_valid = 1'b0;
                end
                else if (char_done)
                begin
                    result.char_valid     = 1'b1;
                    result.char_code      = lookup_code;
                    nxt.garbage_flag      = 1'b0;
                    nxt.pattern_bits      = '0;
                    nxt.pattern_len       = '0;
                    nxt.symbol_time_valid = 1'b0;
                    nxt.char_time         = cur.tick_now;
                    nxt.char_time_valid   = 1'b1;
                end
                else
                begin
                    nxt.gate_mark = cur.tick_now;
                end
            end
        end
        result.tone_on = nxt.tone_state;
    end

    assign next_state = nxt;

endmodule

`default_nettype wire

### rtl/morse_key_timing_decoder_top.sv
// top level of the morse key timing decoder: state memory, update stage, result register
//
//  channel   direction  handshake               payload
//  key       in         key_valid / key_stall   key_level
//  res       out        res_valid / res_stall   tone_on, char_valid, char_code
//  apb       in         psel / penable / pready paddr, pwdata, prdata
//
// one tick per cycle sustained while res_stall is low; each tick passes the update stage, then the result register
// the state word lives in a one-entry memory: read on accept, updated and written back
// when the update stage advances, and a write-back that lands on the same edge as a read is forwarded
// after reset the memory is not cleared; a written flag makes the first read all zero
// key_stall is high only while the update stage is full and the result is held by res_stall
`default_nettype none

module morse_key_timing_decoder_top #(
    parameter int TIME_BITS  = 16,
    parameter int SYMBOL_MAX = 6
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               key_valid,
    output logic                                    key_stall,
    input  wire logic                               key_level,
    output logic                                    res_valid,
    input  wire logic                               res_stall,
    output logic                                    tone_on,
    output logic                                    char_valid,
    output logic      [mkd_pkg::CHAR_BITS-1:0]      char_code,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [mkd_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  wire logic [mkd_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic      [mkd_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                    pready
);

    import mkd_pkg::*;

    localparam int LEN_BITS   = $clog2(SYMBOL_MAX + 1);
    localparam int STATE_BITS = 5 * TIME_BITS + 5 + SYMBOL_MAX + LEN_BITS;

    cfg_t                  cfg;
    res_t                  step_res;
    res_t                  res_reg;
    logic [STATE_BITS-1:0] ram_rd_data;
    logic [STATE_BITS-1:0] cur_state;
    logic [STATE_BITS-1:0] next_state;
    logic [STATE_BITS-1:0] fwd_state_reg;
    logic                  accept;
    logic                  advance;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_key_reg;
    logic                  s1_fwd_reg;
    logic                  s1_fresh_reg;
    logic                  mem_written_reg;
    logic                  res_valid_reg;
    logic                  res_valid_next;

    mkd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance   = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign key_stall = s1_valid_reg && !advance;
    assign accept    = key_valid && !key_stall;

    mkd_ram #(
        .WIDTH (STATE_BITS),
        .DEPTH (1)
    ) u_state_ram (
        .clk     (clk),
        .we      (advance),
        .wr_addr (1'b0),
        .wr_data (next_state),
        .re      (accept),
        .rd_addr (1'b0),
        .rd_data (ram_rd_data)
    );

    assign cur_state = s1_fwd_reg   ? fwd_state_reg :
                       s1_fresh_reg ? '0            : ram_rd_data;

    mkd_step #(
        .TIME_BITS  (TIME_BITS),
        .SYMBOL_MAX (SYMBOL_MAX)
    ) u_step (
        .cur_state  (cur_state),
        .key_level  (s1_key_reg),
        .cfg        (cfg),
        .next_state (next_state),
        .result     (step_res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
            mem_written_reg <= 1'b0;
            s1_fwd_reg      <= 1'b0;
            s1_fresh_reg    <= 1'b1;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                mem_written_reg <= 1'b1;
            end
            if (accept)
            begin
                s1_fwd_reg   <= advance;
                s1_fresh_reg <= !mem_written_reg && !advance;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_key_reg <= key_level;
        end
        if (advance)
        begin
            fwd_state_reg <= next_state;
            res_reg       <= step_res;
        end
    end

    assign res_valid  = res_valid_reg;
    assign tone_on    = res_reg.tone_on;
    assign char_valid = res_reg.char_valid;
    assign char_code  = res_reg.char_code;

    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        key_stall |-> (s1_valid_reg && res_valid_reg && res_stall)
    ) else $error("key_stall without a full pipeline");

    a_result_from_stage: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(s1_valid_reg)
    ) else $error("result appeared without a transaction in the update stage");

    a_char_released: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.char_valid) |-> !res_reg.tone_on
    ) else $error("character emitted while the tone is on");

    a_code_idle_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.char_valid) |-> (res_reg.char_code == CHAR_NONE)
    ) else $error("char_code set without char_valid");

endmodule

`default_nettype wire

### sim/mkd_decode_checker.sv
// tick-by-tick output checker for the morse key timing decoder
`timescale 1ns / 100ps

module mkd_decode_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                key_valid,
    input  wire logic                                key_stall,
    input  wire logic                                key_level,
    input  wire logic                                res_valid,
    input  wire logic                                res_stall,
    input  wire logic                                tone_on,
    input  wire logic                                char_valid,
    input  wire logic [mkd_pkg::CHAR_BITS-1:0]       char_code,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mkd_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  wire logic [mkd_pkg::CFG_DATA_BITS-1:0]   pwdata,
    input  wire logic                                pready,
    output int                                       mismatches,
    output int                                       outstanding
);

    localparam int SYMBOL_MAX = 6;
    localparam int TIME_BITS  = 16;

    typedef logic [TIME_BITS-1:0] tick_t;

    mkd_pkg::cfg_t         timing;
    tick_t                 now_tick;
    tick_t                 gate_tick;
    tick_t                 press_tick;
    tick_t                 symbol_tick;
    tick_t                 char_tick;
    logic                  pressing;
    logic                  symbol_open;
    logic                  char_open;
    logic                  garbage;
    logic                  tone;
    logic [SYMBOL_MAX-1:0] pat_bits;
    int                    pat_len;
    mkd_pkg::res_t         decoded_q[$];

    function automatic tick_t span(input tick_t later, input tick_t earlier);
        return later - earlier;
    endfunction

    // itu table lookup on the dot/dash string, first symbol leftmost
    function automatic logic [7:0] pattern_char();
        string seq;
        seq = "";
        for (int i = 0; i < pat_len; i++)
        begin
            if (pat_bits[i])
            begin
                seq = {seq, "-"};
            end
            else
            begin
                seq = {seq, "."};
            end
        end
        case (seq)
            ".-":     return "A";
            "-...":   return "B";
            "-.-.":   return "C";
            "-..":    return "D";
            ".":      return "E";
            "..-.":   return "F";
            "--.":    return "G";
            "....":   return "H";
            "..":     return "I";
            ".---":   return "J";
            "-.-":    return "K";
            ".-..":   return "L";
            "--":     return "M";
            "-.":     return "N";
            "---":    return "O";
            ".--.":   return "P";
            "--.-":   return "Q";
            ".-.":    return "R";
            "...":    return "S";
            "-":      return "T";
            "..-":    return "U";
            "...-":   return "V";
            ".--":    return "W";
            "-..-":   return "X";
            "-.--":   return "Y";
            "--..":   return "Z";
            "-----":  return "0";
            ".----":  return "1";
            "..---":  return "2";
            "...--":  return "3";
            "....-":  return "4";
            ".....":  return "5";
            "-....":  return "6";
            "--...":  return "7";
            "---..":  return "8";
            "----.":  return "9";
            ".-.-.-": return ".";
            "--..--": return ",";
            "---...": return ":";
            "..--..": return "?";
            ".----.": return "'";
            "-....-": return "-";
            "-..-.":  return "/";
            "-.--.":  return "(";
            "-.--.-": return ")";
            ".-..-.": return "\"";
            "-...-":  return "=";
            ".-.-.":  return "+";
            ".--.-.": return "@";
            default:  return "#";
        endcase
    endfunction

    function automatic mkd_pkg::res_t decode_tick(input logic key);
        mkd_pkg::res_t r;
        tick_t         t;
        logic [7:0]    ascii;
        t            = now_tick;
        r.char_valid = 1'b0;
        r.char_code  = mkd_pkg::CHAR_NONE;
        if (span(t, gate_tick) >= timing.debounce_ticks)
        begin
            if (key)
            begin
                if (!pressing)
                begin
                    pressing   = 1'b1;
                    press_tick = t;
                end
                tone = 1'b1;
            end
            else
            begin
                tone = 1'b0;
                if (pressing)
                begin
                    // pattern already full: drop the press, keep the timers
                    if (pat_len >= SYMBOL_MAX || garbage)
                    begin
                        garbage = 1'b1;
                    end
                    else
                    begin
                        pat_bits[pat_len] = span(t, press_tick) >= timing.dash_threshold;
                        pat_len++;
                        symbol_tick = t;
                        symbol_open = 1'b1;
                        char_open   = 1'b0;
                    end
                    pressing   = 1'b0;
                    press_tick = '0;
                end
                else if (char_open && span(t, char_tick) >= timing.word_gap)
                begin
                    r.char_valid = 1'b1;
                    r.char_code  = mkd_pkg::CHAR_SPACE;
                    char_open    = 1'b0;
                end
                else if (symbol_open && span(t, symbol_tick) >= timing.char_gap)
                begin
                    ascii        = pattern_char();
                    r.char_valid = 1'b1;
                    r.char_code  = ascii[mkd_pkg::CHAR_BITS-1:0];
                    garbage      = 1'b0;
                    pat_bits     = '0;
                    pat_len      = 0;
                    symbol_open  = 1'b0;
                    char_tick    = t;
                    char_open    = 1'b1;
                end
                else
                begin
                    gate_tick = t;
                end
            end
        end
        now_tick  = t + 1'b1;
        r.tone_on = tone;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        mkd_pkg::res_t want;
        if (!rst_n)
        begin
            timing.dash_threshold = mkd_pkg::DASH_THRESHOLD_RESET;
            timing.char_gap       = mkd_pkg::CHAR_GAP_RESET;
            timing.word_gap       = mkd_pkg::WORD_GAP_RESET;
            timing.debounce_ticks = mkd_pkg::DEBOUNCE_TICKS_RESET;
            now_tick    = '0;
            gate_tick   = '0;
            press_tick  = '0;
            symbol_tick = '0;
            char_tick   = '0;
            pressing    = 1'b0;
            symbol_open = 1'b0;
            char_open   = 1'b0;
            garbage     = 1'b0;
            tone        = 1'b0;
            pat_bits    = '0;
            pat_len     = 0;
            decoded_q.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("extra result: tone_on %0b char_valid %0b char_code %0h",
                           tone_on, char_valid, char_code);
                    mismatches++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (tone_on !== want.tone_on)
                    begin
                        $error("tone_on: expected %0b, actual %0b", want.tone_on, tone_on);
                        mismatches++;
                    end
                    if (char_valid !== want.char_valid)
                    begin
                        $error("char_valid: expected %0b, actual %0b", want.char_valid, char_valid);
                        mismatches++;
                    end
                    if (char_code !== want.char_code)
                    begin
                        $error("char_code: expected %0h, actual %0h", want.char_code, char_code);
                        mismatches++;
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    mkd_pkg::REG_DASH_THRESHOLD: timing.dash_threshold = pwdata[15:0];
                    mkd_pkg::REG_CHAR_GAP:       timing.char_gap       = pwdata[15:0];
                    mkd_pkg::REG_WORD_GAP:       timing.word_gap       = pwdata[15:0];
                    mkd_pkg::REG_DEBOUNCE_TICKS: timing.debounce_ticks = pwdata[15:0];
                    default: ;
                endcase
            end
            if (key_valid && !key_stall)
            begin
                decoded_q.push_back(decode_tick(key_level));
            end
            outstanding = decoded_q.size();
        end
    end

endmodule

### sim/morse_key_timing_decoder_top_tb.sv
// stimulus and verdict for the morse key timing decoder
`timescale 1ns / 100ps

module morse_key_timing_decoder_top_tb;

    localparam int PHASES      = 16;
    localparam int PHASE_TICKS = 70;

    logic                                clk;
    logic                                rst_n;
    logic                                key_valid;
    logic                                key_stall;
    logic                                key_level;
    logic                                res_valid;
    logic                                res_stall;
    logic                                tone_on;
    logic                                char_valid;
    logic [mkd_pkg::CHAR_BITS-1:0]       char_code;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [mkd_pkg::CFG_ADDR_BITS-1:0]   paddr;
    logic [mkd_pkg::CFG_DATA_BITS-1:0]   pwdata;
    logic [mkd_pkg::CFG_DATA_BITS-1:0]   prdata;
    logic                                pready;
    int                                  mismatches;
    int                                  outstanding;

    int ticks_sent;
    int cur_dash;
    int cur_char;
    int cur_word;
    bit key_quiet;
    bit res_quiet;

    morse_key_timing_decoder_top u_top (.*);

    mkd_decode_checker u_checker (.*);

    initial clk = 1'b0;

    always #10 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_len(input bit quiet);
        int r;
        if (quiet)
        begin
            return 0;
        end
        r = int'($urandom_range(0, 99));
        if (r < 65)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return int'($urandom_range(1, 3));
        end
        return int'($urandom_range(8, 30));
    endfunction

    // run length under, at or just over a threshold; thresholds out of reach give short runs
    function automatic int reach(input int limit, input bit over);
        if (limit > 1000)
        begin
            return int'($urandom_range(1, 4));
        end
        if (over)
        begin
            return int'($urandom_range(limit, limit + 2));
        end
        return (limit > 1) ? int'($urandom_range(1, limit - 1)) : 1;
    endfunction

    task automatic send_tick(input logic level);
        int gap;
        gap = idle_len(key_quiet);
        if (gap > 0)
        begin
            key_valid <= 1'b0;
            key_level <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge clk);
        end
        key_valid <= 1'b1;
        key_level <= level;
        @(posedge clk);
        while (key_stall) @(posedge clk);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic key_run(input logic level, input int n);
        repeat (n) send_tick(level);
    endtask

    task automatic send_sequence(input int max_sym);
        int count;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
        end
        else
        begin
            if (max_sym > 6 && $urandom_range(0, 5) == 0)
            begin
                count = int'($urandom_range(7, max_sym));
            end
            else
            begin
                count = int'($urandom_range(1, (max_sym < 6) ? max_sym : 6));
            end
            for (int s = 0; s < count; s++)
            begin
                key_run(1'b1, reach(cur_dash, 1'($urandom_range(0, 1))));
                if (s < count - 1)
                begin
                    key_run(1'b0, reach(cur_char, 1'b0));
                end
            end
            case ($urandom_range(0, 3))
                0:       key_run(1'b0, reach(cur_char, 1'b0));
                1, 2:    key_run(1'b0, reach(cur_char, 1'b1));
                default: key_run(1'b0, reach(cur_char, 1'b1) + reach(cur_word, 1'b1));
            endcase
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_timing(input int dash, input int cgap, input int wgap, input int gate);
        write_reg(mkd_pkg::REG_DASH_THRESHOLD, 16'(dash));
        write_reg(mkd_pkg::REG_CHAR_GAP, 16'(cgap));
        write_reg(mkd_pkg::REG_WORD_GAP, 16'(wgap));
        write_reg(mkd_pkg::REG_DEBOUNCE_TICKS, 16'(gate));
        cur_dash = dash;
        cur_char = cgap;
        cur_word = wgap;
    endtask

    task automatic settle();
        key_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin : stall_gen
        int hold;
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            hold = idle_len(res_quiet);
            if (hold > 0)
            begin
                res_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            res_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        int start;
        rst_n      = 1'b0;
        key_valid  = 1'b0;
        key_level  = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        key_quiet  = 1'b0;
        res_quiet  = 1'b0;
        ticks_sent = 0;
        cur_dash   = int'(mkd_pkg::DASH_THRESHOLD_RESET);
        cur_char   = int'(mkd_pkg::CHAR_GAP_RESET);
        cur_word   = int'(mkd_pkg::WORD_GAP_RESET);
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // timing out of reset
        while (ticks_sent < 300) send_sequence(2);
        settle();

        load_timing(2, 2, 3, 0);
        key_run(1'b1, 1);
        key_run(1'b0, 3);
        // word gap after the single dot
        key_run(1'b0, 3);
        key_run(1'b1, 2);
        key_run(1'b0, 3);
        // six symbols then one more press that gets dropped
        for (int i = 0; i < 7; i++)
        begin
            key_run(1'b1, (i % 2 == 1) ? 2 : 1);
            key_run(1'b0, 1);
        end
        key_run(1'b0, 2);
        settle();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       load_timing(3, 4, 8, 0);
                1:       load_timing(2, 3, 5, 1);
                2:       load_timing(1, 2, 3, 0);
                3:       load_timing(65535, 3, 6, 0);
                4:       load_timing(4, 65535, 7, 0);
                5:       load_timing(3, 4, 65535, 0);
                6:       load_timing(3, 1, 1, 0);
                7:       load_timing(3, 4, 8, 2);
                8:       load_timing(3, 4, 8, 65535);
                default: load_timing(int'($urandom_range(1, 6)), int'($urandom_range(1, 8)),
                                     int'($urandom_range(1, 12)), int'($urandom_range(0, 3)));
            endcase
            key_quiet = ($urandom_range(0, 3) == 0);
            res_quiet = ($urandom_range(0, 3) == 0);
            start = ticks_sent;
            while (ticks_sent - start < PHASE_TICKS) send_sequence(9);
            settle();
        end

        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/mkd_pkg.sv
rtl/mkd_ram.sv
rtl/mkd_cfg.sv
rtl/mkd_step.sv
rtl/morse_key_timing_decoder_top.sv
sim/mkd_decode_checker.sv
sim/morse_key_timing_decoder_top_tb.sv
